@@ sv/ptb_pkg.sv @@
package ptb_pkg;

    localparam int ACC_W     = 32;
    localparam int TIME_W    = 48;
    localparam int EPS_W     = 32;
    localparam int ETA_W     = 16;
    localparam int BIN_W     = 6;
    localparam int MASK_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;

    localparam int MAX_BIN_DEF = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ETA      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME     = 3'd4;

    localparam logic [MASK_W-1:0] WM_NONE = 2'd0;
    localparam logic [MASK_W-1:0] WM_STEP = 2'd1;
    localparam logic [MASK_W-1:0] WM_FULL = 2'd2;

    localparam logic [ETA_W-1:0] ETA_RESET = 16'd16384;

    typedef struct packed {
        logic active;
        logic last;
    } ptb_flags_t;

    typedef struct packed {
        logic       a_zero;
        ptb_flags_t flags;
    } ptb_side_t;

endpackage

@@ sv/ptb_isqrt.sv @@
module ptb_isqrt #(
    parameter int SW = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [63:0]   in_value,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [31:0]   out_root,
    output logic [SW-1:0] out_side
);

    localparam int N = 32;

    logic          v_reg    [0:N];
    logic [63:0]   x_reg    [0:N];
    logic [33:0]   rem_reg  [0:N];
    logic [31:0]   root_reg [0:N];
    logic [SW-1:0] side_reg [0:N];
    logic          rdy      [1:N+1];

    always_comb begin
        v_reg[0]    = in_valid;
        x_reg[0]    = in_value;
        rem_reg[0]  = '0;
        root_reg[0] = '0;
        side_reg[0] = in_side;
    end

    assign rdy[N+1] = out_ready;

    genvar i;
    generate
        for (i = 1; i <= N; i++) begin : g_stage
            logic [35:0] rem_sh;
            logic [35:0] trial;
            logic [33:0] rem_next;
            logic [31:0] root_next;

            assign rdy[i] = !v_reg[i] || rdy[i+1];

            always_comb begin
                rem_sh = {rem_reg[i-1], x_reg[i-1][63:62]};
                trial  = {2'b00, root_reg[i-1], 2'b01};
                if (rem_sh >= trial) begin
                    rem_next  = 34'(rem_sh - trial);
                    root_next = {root_reg[i-1][30:0], 1'b1};
                end else begin
                    rem_next  = rem_sh[33:0];
                    root_next = {root_reg[i-1][30:0], 1'b0};
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[i] <= 1'b0;
                end else if (rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
                if (rdy[i] && v_reg[i-1]) begin
                    x_reg[i]    <= {x_reg[i-1][61:0], 2'b00};
                    rem_reg[i]  <= rem_next;
                    root_reg[i] <= root_next;
                    side_reg[i] <= side_reg[i-1];
                end
            end
        end
    endgenerate

    assign in_ready  = rdy[1];
    assign out_valid = v_reg[N];
    assign out_root  = root_reg[N];
    assign out_side  = side_reg[N];

endmodule

@@ sv/ptb_div.sv @@
module ptb_div #(
    parameter int SW = 3
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [63:0]   in_dividend,
    input  logic [31:0]   in_divisor,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [63:0]   out_quot,
    output logic [SW-1:0] out_side
);

    localparam int N = 64;

    logic          v_reg    [0:N];
    logic [63:0]   n_reg    [0:N];
    logic [31:0]   d_reg    [0:N];
    logic [31:0]   rem_reg  [0:N];
    logic [SW-1:0] side_reg [0:N];
    logic          rdy      [1:N+1];

    always_comb begin
        v_reg[0]    = in_valid;
        n_reg[0]    = in_dividend;
        d_reg[0]    = in_divisor;
        rem_reg[0]  = '0;
        side_reg[0] = in_side;
    end

    assign rdy[N+1] = out_ready;

    genvar i;
    generate
        for (i = 1; i <= N; i++) begin : g_stage
            logic [32:0] rem_sh;
            logic [31:0] rem_next;
            logic        qbit;

            assign rdy[i] = !v_reg[i] || rdy[i+1];

            always_comb begin
                rem_sh = {rem_reg[i-1], n_reg[i-1][63]};
                if (rem_sh >= {1'b0, d_reg[i-1]}) begin
                    rem_next = 32'(rem_sh - {1'b0, d_reg[i-1]});
                    qbit     = 1'b1;
                end else begin
                    rem_next = rem_sh[31:0];
                    qbit     = 1'b0;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[i] <= 1'b0;
                end else if (rdy[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
                if (rdy[i] && v_reg[i-1]) begin
                    n_reg[i]    <= {n_reg[i-1][62:0], qbit};
                    d_reg[i]    <= d_reg[i-1];
                    rem_reg[i]  <= rem_next;
                    side_reg[i] <= side_reg[i-1];
                end
            end
        end
    endgenerate

    assign in_ready  = rdy[1];
    assign out_valid = v_reg[N];
    assign out_quot  = n_reg[N];
    assign out_side  = side_reg[N];

endmodule

@@ sv/power_of_two_timestep_binner_top.sv @@
// Power-of-two timestep binner. Takes one particle per beat and returns one result beat
// per particle, in order, accepting a new particle every cycle while m_tready does not
// stall the output. Pipeline: three front stages (magnitude, squares, sum), a 32-stage
// square root, a 64-stage divider, a second 32-stage square root, and four back stages
// (eta multiply, step clamp, bin select, end time). Configuration is written through
// cfg_we/cfg_addr/cfg_wdata and must only change while no particle is in flight.
module power_of_two_timestep_binner_top #(
    parameter int MAX_BIN = ptb_pkg::MAX_BIN_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [ptb_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [ptb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [95:0]                     s_tdata,  // accel_x, accel_y, accel_z
    input  logic                            s_tuser,  // particle_active
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [103:0]                    m_tdata,  // bin_index, step_length, step_end, pad
    output logic [2:0]                      m_tuser,  // write_mask, bin_saturated
    output logic                            m_tlast
);

    import ptb_pkg::*;

    logic              mode_reg;
    logic [TIME_W-1:0] max_step_reg;
    logic [EPS_W-1:0]  eps_reg;
    logic [ETA_W-1:0]  eta_reg;
    logic [TIME_W-1:0] time_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= 1'b1;
            max_step_reg <= '0;
            eps_reg      <= '0;
            eta_reg      <= ETA_RESET;
            time_reg     <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_MODE:     mode_reg     <= cfg_wdata[0];
                CFG_MAX_STEP: max_step_reg <= cfg_wdata[TIME_W-1:0];
                CFG_EPS:      eps_reg      <= cfg_wdata[EPS_W-1:0];
                CFG_ETA:      eta_reg      <= cfg_wdata[ETA_W-1:0];
                CFG_TIME:     time_reg     <= cfg_wdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // front stages
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;
    logic [31:0] mx_reg, my_reg, mz_reg;
    logic [63:0] sx_reg, sy_reg, sz_reg, sum_reg;
    ptb_flags_t  f1_reg, f2_reg, f3_reg;
    logic        sqa_in_ready;

    assign rdy3 = !v3_reg || sqa_in_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_tready = rdy1;

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? 32'(~v + 32'd1) : v;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
        if (rdy1 && s_tvalid) begin
            mx_reg <= abs32(s_tdata[31:0]);
            my_reg <= abs32(s_tdata[63:32]);
            mz_reg <= abs32(s_tdata[95:64]);
            f1_reg <= '{active: s_tuser, last: s_tlast};
        end
        if (rdy2 && v1_reg) begin
            sx_reg <= {32'd0, mx_reg} * {32'd0, mx_reg};
            sy_reg <= {32'd0, my_reg} * {32'd0, my_reg};
            sz_reg <= {32'd0, mz_reg} * {32'd0, mz_reg};
            f2_reg <= f1_reg;
        end
        if (rdy3 && v2_reg) begin
            sum_reg <= sx_reg + sy_reg + sz_reg;
            f3_reg  <= f2_reg;
        end
    end

    // magnitude, quotient, root
    logic        sqa_out_valid, div_in_ready;
    logic [31:0] amag;
    ptb_flags_t  fa;

    ptb_isqrt #(.SW($bits(ptb_flags_t))) u_sqrt_mag (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v3_reg),
        .in_ready  (sqa_in_ready),
        .in_value  (sum_reg),
        .in_side   (f3_reg),
        .out_valid (sqa_out_valid),
        .out_ready (div_in_ready),
        .out_root  (amag),
        .out_side  (fa)
    );

    ptb_side_t   div_side_in, div_side_out;
    logic        div_out_valid, sqb_in_ready;
    logic [63:0] quot;

    assign div_side_in = '{a_zero: (amag == 32'd0), flags: fa};

    ptb_div #(.SW($bits(ptb_side_t))) u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (sqa_out_valid),
        .in_ready    (div_in_ready),
        .in_dividend ({eps_reg, 32'd0}),
        .in_divisor  (amag),
        .in_side     (div_side_in),
        .out_valid   (div_out_valid),
        .out_ready   (sqb_in_ready),
        .out_quot    (quot),
        .out_side    (div_side_out)
    );

    logic        sqb_out_valid, rdy4;
    logic [31:0] sroot;
    ptb_side_t   sb;

    ptb_isqrt #(.SW($bits(ptb_side_t))) u_sqrt_ratio (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_out_valid),
        .in_ready  (sqb_in_ready),
        .in_value  (quot),
        .in_side   (div_side_out),
        .out_valid (sqb_out_valid),
        .out_ready (rdy4),
        .out_root  (sroot),
        .out_side  (sb)
    );

    // back stages
    logic v4_reg, v5_reg, v6_reg, v7_reg;
    logic rdy5, rdy6, rdy7;
    logic [47:0]       prod_reg;
    logic [TIME_W-1:0] dt_reg, step_reg;
    logic [BIN_W-1:0]  bin_reg;
    logic              bsat_reg;
    ptb_side_t         sd4_reg;
    ptb_flags_t        sd5_reg;
    ptb_flags_t        f6_reg;

    logic [BIN_W-1:0]  out_bin_reg;
    logic [TIME_W-1:0] out_step_reg, out_end_reg;
    logic [MASK_W-1:0] out_mask_reg;
    logic              out_sat_reg, out_last_reg;

    assign rdy7 = !v7_reg || m_tready;
    assign rdy6 = !v6_reg || rdy7;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;

    logic [49:0]       g_full;
    logic [TIME_W-1:0] g_sat, dt_next;

    always_comb begin
        g_full = {prod_reg, 2'b00};
        g_sat  = (g_full[49:48] != 2'b00) ? {TIME_W{1'b1}} : g_full[47:0];
        if (sd4_reg.a_zero || g_sat >= max_step_reg) begin
            dt_next = max_step_reg;
        end else begin
            dt_next = g_sat;
        end
    end

    logic [MAX_BIN:0]  fits;
    logic [BIN_W-1:0]  bin_next;
    logic              bsat_next;

    always_comb begin
        for (int n = 0; n <= MAX_BIN; n++) begin
            fits[n] = (max_step_reg >> n) <= dt_reg;
        end
        bin_next  = BIN_W'(MAX_BIN);
        bsat_next = !fits[MAX_BIN];
        for (int n = MAX_BIN; n >= 0; n--) begin
            if (fits[n]) begin
                bin_next = BIN_W'(n);
            end
        end
    end

    logic [TIME_W:0] end_sum;
    assign end_sum = {1'b0, time_reg} + {1'b0, step_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            if (rdy4) v4_reg <= sqb_out_valid;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
            if (rdy7) v7_reg <= v6_reg;
        end
        if (rdy4 && sqb_out_valid) begin
            prod_reg <= {16'd0, sroot} * {32'd0, eta_reg};
            sd4_reg  <= sb;
        end
        if (rdy5 && v4_reg) begin
            dt_reg  <= dt_next;
            sd5_reg <= sd4_reg.flags;
        end
        if (rdy6 && v5_reg) begin
            bin_reg  <= bin_next;
            bsat_reg <= bsat_next;
            step_reg <= max_step_reg >> bin_next;
            f6_reg   <= sd5_reg;
        end
        if (rdy7 && v6_reg) begin
            out_last_reg <= f6_reg.last;
            if (!mode_reg) begin
                out_bin_reg  <= '0;
                out_step_reg <= max_step_reg;
                out_end_reg  <= '0;
                out_mask_reg <= WM_STEP;
                out_sat_reg  <= 1'b0;
            end else if (f6_reg.active) begin
                out_bin_reg  <= bin_reg;
                out_step_reg <= step_reg;
                out_end_reg  <= end_sum[TIME_W] ? {TIME_W{1'b1}} : end_sum[TIME_W-1:0];
                out_mask_reg <= WM_FULL;
                out_sat_reg  <= bsat_reg || end_sum[TIME_W];
            end else begin
                out_bin_reg  <= '0;
                out_step_reg <= '0;
                out_end_reg  <= '0;
                out_mask_reg <= WM_NONE;
                out_sat_reg  <= 1'b0;
            end
        end
    end

    assign m_tvalid = v7_reg;
    assign m_tdata  = {2'b00, out_end_reg, out_step_reg, out_bin_reg};
    assign m_tuser  = {out_sat_reg, out_mask_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTHESIS
    a_mask_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[1:0] == WM_NONE || m_tuser[1:0] == WM_STEP
                      || m_tuser[1:0] == WM_FULL))
        else $error("write mask out of range");

    a_bin_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] <= BIN_W'(MAX_BIN)))
        else $error("bin above limit");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_sat_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == WM_FULL))
        else $error("saturation flag without full update");
`endif

endmodule

@@ tb/power_of_two_timestep_binner_top_tb.sv @@
`timescale 1ns / 100ps

module power_of_two_timestep_binner_top_tb;
    import ptb_pkg::*;

    localparam int MAX_BIN_TB = MAX_BIN_DEF;
    localparam int DRAIN_CYCLES = 160;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam longint unsigned MASK48 = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [BIN_W-1:0]  bin;
        logic [TIME_W-1:0] step;
        logic [TIME_W-1:0] step_end;
        logic [MASK_W-1:0] mask;
        logic              sat;
        logic              last;
    } bin_result_t;

    class binner_scoreboard;
        logic              mode;
        logic [TIME_W-1:0] max_step;
        logic [EPS_W-1:0]  eps;
        logic [ETA_W-1:0]  eta;
        logic [TIME_W-1:0] now;
        bin_result_t       pending[$];
        int                errors;

        function new();
            mode = 1'b1;
            max_step = '0;
            eps = '0;
            eta = ETA_RESET;
            now = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_MODE:     mode = val[0];
                CFG_MAX_STEP: max_step = val[TIME_W-1:0];
                CFG_EPS:      eps = val[EPS_W-1:0];
                CFG_ETA:      eta = val[ETA_W-1:0];
                CFG_TIME:     now = val[TIME_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function longint unsigned abs32(logic [31:0] v);
            logic [31:0] m;
            m = v[31] ? (~v + 32'd1) : v;
            return {32'd0, m};
        endfunction

        function void note_particle(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                    logic active, logic last);
            bin_result_t r;
            longint unsigned mx, my, mz, amag, dt, q, s, g, st, total;
            int n;
            r.bin = '0;
            r.step = '0;
            r.step_end = '0;
            r.mask = WM_NONE;
            r.sat = 1'b0;
            r.last = last;
            if (!mode) begin
                r.step = max_step;
                r.mask = WM_STEP;
            end else if (active) begin
                mx = abs32(ax);
                my = abs32(ay);
                mz = abs32(az);
                amag = int_sqrt(mx * mx + my * my + mz * mz);
                dt = max_step;
                if (amag != 0) begin
                    q = ({32'd0, eps} << 32) / amag;
                    s = int_sqrt(q);
                    g = (s * eta) << 2;
                    if (g > MASK48) g = MASK48;
                    if (g < dt) dt = g;
                end
                st = max_step;
                n = 0;
                while (st > dt && n < MAX_BIN_TB) begin
                    st = st >> 1;
                    n++;
                end
                if (st > dt) r.sat = 1'b1;
                total = now + st;
                if (total > MASK48) begin
                    total = MASK48;
                    r.sat = 1'b1;
                end
                r.bin = n[BIN_W-1:0];
                r.step = st[TIME_W-1:0];
                r.step_end = total[TIME_W-1:0];
                r.mask = WM_FULL;
            end
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(logic [103:0] data, logic [2:0] user, logic last);
            bin_result_t e;
            if (pending.size() == 0) begin
                $error("unexpected result beat data=%h user=%h", data, user);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[5:0] !== e.bin) begin
                $error("bin_index expected %0d actual %0d", e.bin, data[5:0]);
                errors++;
            end
            if (data[53:6] !== e.step) begin
                $error("step_length expected %h actual %h", e.step, data[53:6]);
                errors++;
            end
            if (data[101:54] !== e.step_end) begin
                $error("step_end expected %h actual %h", e.step_end, data[101:54]);
                errors++;
            end
            if (user[1:0] !== e.mask) begin
                $error("write_mask expected %0d actual %0d", e.mask, user[1:0]);
                errors++;
            end
            if (user[2] !== e.sat) begin
                $error("bin_saturated expected %0d actual %0d", e.sat, user[2]);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_out expected %0d actual %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [95:0]           s_tdata = '0;   // accel_x, accel_y, accel_z
    logic                  s_tuser = 1'b0; // particle_active
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [103:0]          m_tdata;        // bin_index, step_length, step_end, pad
    logic [2:0]            m_tuser;        // write_mask, bin_saturated
    logic                  m_tlast;

    binner_scoreboard sb = new();
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 0;
    int  cycles = 0;

    power_of_two_timestep_binner_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_particle(s_tdata[31:0], s_tdata[63:32], s_tdata[95:64], s_tuser, s_tlast);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic send_particle(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                 logic active, logic last);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {az, ay, ax};
        s_tuser <= active;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_accel();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0: v = 32'h0;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h8000_0000;
            3, 4: v = $urandom();
            default: v = $signed($urandom()) >>> $urandom_range(0, 31);
        endcase
        return v;
    endfunction

    task automatic configure(int ph);
        logic [47:0] ms, tm;
        logic [31:0] ep;
        logic [15:0] et;
        ms = 48'({$urandom(), $urandom()} >> $urandom_range(0, 20));
        tm = 48'({$urandom(), $urandom()} >> $urandom_range(4, 30));
        ep = $urandom() >> $urandom_range(0, 16);
        et = 16'($urandom_range(1, 65535));
        case (ph)
            1: ms = MASK48[47:0];
            2: ep = '0;
            3: et = '0;
            4: et = 16'hFFFF;
            5: tm = 48'(MASK48 - 64'($urandom_range(0, 1000)));
            6: ms = '0;
            7: ep = 32'hFFFF_FFFF;
            8: ms = 48'h1_0000_0000;
            default: ;
        endcase
        write_reg(CFG_MODE, (ph == 9 || ph == 13) ? 48'd0 : 48'd1);
        write_reg(CFG_MAX_STEP, ms);
        write_reg(CFG_EPS, {16'd0, ep});
        write_reg(CFG_ETA, {32'd0, et});
        write_reg(CFG_TIME, tm);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int i;
        int ph;
        int count;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_particle(32'h0, 32'h0, 32'h0, 1'b1, 1'b0);
        send_particle(32'h0001_0000, 32'h0, 32'h0, 1'b1, 1'b0);
        s_tvalid <= 1'b0;
        wait_drained();

        configure(0);
        send_particle(32'h0, 32'h0, 32'h0, 1'b1, 1'b0);
        send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0);
        send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
        send_particle(32'hFFFF_FFFF, 32'h0, 32'h1, 1'b1, 1'b0);
        send_particle(32'h0000_0001, 32'h0, 32'h0, 1'b1, 1'b0);
        send_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0);
        send_particle(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 1'b1, 1'b0);
        send_particle(32'h0, 32'h0, 32'h0, 1'b0, 1'b1);
        s_tvalid <= 1'b0;
        wait_drained();

        for (ph = 0; ph < 16; ph++) begin
            configure(ph);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            count = (ph == 4) ? 200 : 59;
            if (ph == 4) hold_req = 1;
            for (i = 0; i < count; i++) begin
                if (ph == 6 && i == 30) begin
                    s_tvalid <= 1'b0;
                    while (sb.pending.size() != 0) @(posedge aclk);
                end
                send_particle(rand_accel(), rand_accel(), rand_accel(),
                              $urandom_range(0, 9) != 0,
                              (i == count - 1) || ($urandom_range(0, 15) == 0));
            end
            s_tvalid <= 1'b0;
            wait_drained();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
